// ===== rtl/core/mts_pkg.sv =====
package mts_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int FILL_W      = $clog2(STACK_DEPTH + 1);

    localparam int VALUE_W     = 32;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 11;

    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 48;

    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] min_value;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

endpackage

// ===== rtl/core/min_tracking_stack_unit.sv =====
// An input item is registered together with the top entry read from the entry memory; in the
// EXEC state, once the output register is free, the result for the master side is registered.
// The input side takes no new item while one is in the EXEC state, where the entry memory is written.
// The input side takes the next item while a finished result waits at the output.
// Reset (rst_n low, asynchronous) empties the stack and clears the handshake state;
// the entry memory is not cleared and no clearing pass runs.
module min_tracking_stack_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mts_pkg::S_TDATA_W-1:0]    s_tdata,   // [31:0] push_value
    input  logic [mts_pkg::MODE_W-1:0]       s_tuser,   // [1:0] mode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mts_pkg::M_TDATA_W-1:0]    m_tdata,   // [31:0] result_value, [42:32] entry_count
    output logic [mts_pkg::STATUS_W-1:0]     m_tuser    // [1:0] status
);
    import mts_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                       state_reg, state_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic [MODE_W-1:0]          mode_reg;
    logic signed [VALUE_W-1:0]  value_reg;

    logic                       out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0]  out_result_reg, out_result_next;
    logic [STATUS_W-1:0]        out_status_reg, out_status_next;
    logic [COUNT_W-1:0]         out_count_reg, out_count_next;

    entry_t                     mem [STACK_DEPTH];
    entry_t                     rd_data_reg;
    logic [ADDR_W-1:0]          rd_addr;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    entry_t                     wr_data;

    logic                       in_xfer;
    logic                       out_free;
    logic                       stack_empty;
    logic                       stack_full;

    assign in_xfer     = s_tvalid && s_tready;
    assign out_free    = !out_valid_reg || m_tready;
    assign stack_empty = (fill_reg == '0);
    assign stack_full  = (fill_reg == FILL_W'(STACK_DEPTH));

    // top entry sits one below the fill count
    assign rd_addr = ADDR_W'(fill_reg - FILL_W'(1));

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - COUNT_W - VALUE_W){1'b0}}, out_count_reg, out_result_reg};
    assign m_tuser  = out_status_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg  <= s_tuser;
            value_reg <= s_tdata[VALUE_W-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        wr_en           = 1'b0;
        wr_addr         = fill_reg[ADDR_W-1:0];
        wr_data.value   = value_reg;
        wr_data.min_value = value_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold until the output register can take the result
                if (out_free)
                begin
                    out_result_next = '0;
                    out_status_next = ST_OK;
                    case (mode_reg)
                        MODE_PUSH:
                        begin
                            if (stack_full)
                            begin
                                out_status_next = ST_FULL;
                            end
                            else
                            begin
                                if (!stack_empty && (rd_data_reg.min_value < value_reg))
                                begin
                                    wr_data.min_value = rd_data_reg.min_value;
                                end
                                wr_en     = 1'b1;
                                fill_next = fill_reg + FILL_W'(1);
                            end
                        end
                        MODE_POP:
                        begin
                            if (stack_empty)
                            begin
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                out_result_next = rd_data_reg.value;
                                fill_next       = fill_reg - FILL_W'(1);
                            end
                        end
                        MODE_QUERY:
                        begin
                            if (stack_empty)
                            begin
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                out_result_next = rd_data_reg.min_value;
                            end
                        end
                        default:
                        begin
                            out_status_next = ST_OK;
                        end
                    endcase
                    out_count_next = COUNT_W'(fill_next);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_result_reg <= out_result_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

endmodule
